### hw/rtl/prs32_pkg.sv
package prs32_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int PHASE_TAPS     = 23;
	localparam int TAP_IDX_BITS   = $clog2(PHASE_TAPS);
	localparam int TABLE_FRAC     = 17;
	localparam int TABLE_BITS     = TABLE_FRAC + 1;
	localparam int FILL_INDEX     = 12;
	localparam int FILL_BITS      = 4;
	localparam int ZERO_TAIL      = 13;
	localparam int MAX_RESULTS    = 10;
	localparam int COUNT_BITS     = 4;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] in_sample;
		logic                          in_last;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_sample;
		logic                          run_last;
		logic                          stream_last;
	} out_word_t;

	// windowed-sinc taps, Q1.17, phase 0 then phase 1
	localparam logic signed [TABLE_BITS-1:0] COEF_TAB [0:1][0:PHASE_TAPS-1] = '{
		'{18'sd0, 18'sd0, -18'sd141, 18'sd692, -18'sd226, -18'sd2847, 18'sd5603,
		  -18'sd659, -18'sd15592, 18'sd35480, 18'sd86508, 18'sd35480, -18'sd15592,
		  -18'sd659, 18'sd5603, -18'sd2847, -18'sd226, 18'sd692, -18'sd141,
		  18'sd0, 18'sd0, 18'sd0, 18'sd0},
		'{18'sd0, 18'sd0, 18'sd0, -18'sd48, 18'sd64, 18'sd950, -18'sd2353,
		  18'sd443, 18'sd6672, -18'sd12263, 18'sd816, 18'sd71288, 18'sd71288,
		  18'sd816, -18'sd12263, 18'sd6672, 18'sd443, -18'sd2353, 18'sd950,
		  18'sd64, -18'sd48, 18'sd0, 18'sd0}
	};

endpackage

### hw/rtl/polyphase_resampler_3to2.sv
// 24 kHz to 16 kHz resampler: two-phase polyphase windowed-sinc FIR, 23 taps per phase.
// Input channel: in_valid / in_stall / in_data carry one Q1.15 sample and a last flag.
// Output channel: out_valid / out_stall / out_data carry one Q1.15 sample plus
// run_last (last word caused by this input) and stream_last (last word of the stream).
// One shared multiply-accumulate unit walks the 23 taps of a phase, one tap per cycle,
// so each output word passes through setup, 23 products, drain, round and step.
// A sample that gives no output passes through ST_POST and ST_FIN; every third sample, once
// twelve samples have been seen, gives two words. Each word waits in a holding register
// until the next one is ready, so run_last can be set. in_stall is high while an item
// is being worked on. The sample marked last shifts in up to 13 zeros and gives the
// remaining words; then the block clears its delay line and counters and returns to idle.
// A stalled output word holds in the output register; the block finishes the next
// product sum meanwhile and then waits. Reset clears the delay line and counters.
module polyphase_resampler_3to2 #(
	parameter int COEF_BITS   = 18,
	parameter int LENGTH_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  prs32_pkg::in_word_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output prs32_pkg::out_word_t out_data
);
	import prs32_pkg::*;

	localparam int ACC_W = SAMPLE_BITS + COEF_BITS + TAP_IDX_BITS;
	localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
	localparam int CMP_W = LENGTH_BITS + 2;
	localparam int COEF_SHIFT = COEF_BITS - 1 - TABLE_FRAC;
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(2 ** (SAMPLE_BITS - 1)));
	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEF_BITS - 2);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_START = 9'b000000010,
		ST_MAC   = 9'b000000100,
		ST_DRAIN = 9'b000001000,
		ST_EMIT  = 9'b000010000,
		ST_NEXT  = 9'b000100000,
		ST_POST  = 9'b001000000,
		ST_FLUSH = 9'b010000000,
		ST_FIN   = 9'b100000000
	} state_t;

	state_t                        state_q;
	logic signed [SAMPLE_BITS-1:0] dl_q [PHASE_TAPS];
	logic [LENGTH_BITS-1:0]        seen_q;
	logic [LENGTH_BITS-1:0]        given_q;
	logic [1:0]                    ph_q;
	logic [FILL_BITS-1:0]          fill_q;
	logic [TAP_IDX_BITS-1:0]       k_q;
	logic                          p_q;
	logic                          last_q;
	logic                          flush_q;
	logic [FILL_BITS-1:0]          pad_q;
	logic [COUNT_BITS-1:0]         cnt_q;
	logic                          pend_valid_q;
	logic signed [SAMPLE_BITS-1:0] pend_sample_q;
	logic                          prod_v_s1;
	logic signed [PROD_W-1:0]      prod_s1;
	logic signed [ACC_W-1:0]       acc_q;
	logic                          out_valid_q;
	out_word_t                     out_data_q;

	logic signed [24:0]            coef_raw;
	logic signed [COEF_BITS-1:0]   coef_val;
	logic [CMP_W-1:0]              given3;
	logic [CMP_W-1:0]              seen2;
	logic                          below_target;
	logic                          fill_full;
	logic                          slot_free;
	logic                          emit_go;
	logic                          fin_go;
	logic                          push;
	logic signed [ACC_W-1:0]       rsum;
	logic signed [ACC_W-1:0]       rshift;
	logic signed [SAMPLE_BITS-1:0] rounded;
	logic [1:0]                    ph_next;
	logic [FILL_BITS-1:0]          fill_next;

	assign coef_raw = 25'(COEF_TAB[p_q][k_q]);

	generate
		if (COEF_SHIFT >= 0) begin : g_coef_up
			assign coef_val = COEF_BITS'(coef_raw <<< COEF_SHIFT);
		end else begin : g_coef_down
			localparam int RS = -COEF_SHIFT;
			assign coef_val = COEF_BITS'((coef_raw + (25'sd1 <<< (RS - 1))) >>> RS);
		end
	endgenerate

	// outputs_given < (2*seen+2)/3  <=>  3*given + 1 <= 2*seen
	assign given3 = CMP_W'({given_q, 1'b0}) + CMP_W'(given_q) + CMP_W'(1);
	assign seen2 = CMP_W'({seen_q, 1'b0});
	assign below_target = given3 <= seen2;

	assign fill_full = fill_q == FILL_BITS'(FILL_INDEX);
	assign fill_next = fill_full ? fill_q : fill_q + FILL_BITS'(1);
	assign ph_next = (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;

	assign slot_free = !out_valid_q || !out_stall;
	assign emit_go = (state_q == ST_EMIT) && (!pend_valid_q || slot_free);
	assign fin_go = (state_q == ST_FIN) && (!pend_valid_q || slot_free);
	assign push = (emit_go || fin_go) && pend_valid_q;

	assign rsum = acc_q + ROUND_HALF;
	assign rshift = rsum >>> (COEF_BITS - 1);

	always_comb begin
		if (rshift > SAT_HI) begin
			rounded = SAT_HI[SAMPLE_BITS-1:0];
		end else if (rshift < SAT_LO) begin
			rounded = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			rounded = rshift[SAMPLE_BITS-1:0];
		end
	end

	assign in_stall = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			for (int i = 0; i < PHASE_TAPS; i++) begin
				dl_q[i] <= '0;
			end
			seen_q       <= '0;
			given_q      <= '0;
			ph_q         <= '0;
			fill_q       <= '0;
			k_q          <= '0;
			p_q          <= 1'b0;
			last_q       <= 1'b0;
			flush_q      <= 1'b0;
			pad_q        <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			prod_v_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			prod_v_s1 <= state_q == ST_MAC;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						for (int i = 0; i < PHASE_TAPS - 1; i++) begin
							dl_q[i] <= dl_q[i+1];
						end
						dl_q[PHASE_TAPS-1] <= in_data.in_sample;
						last_q  <= in_data.in_last;
						flush_q <= 1'b0;
						if (seen_q != '1) begin
							seen_q <= seen_q + LENGTH_BITS'(1);
						end
						ph_q   <= ph_next;
						fill_q <= fill_next;
						p_q    <= 1'b0;
						if (ph_q == 2'd0 && fill_full) begin
							state_q <= ST_START;
						end else begin
							state_q <= ST_POST;
						end
					end
				end
				ST_START: begin
					k_q <= '0;
					// drop the word once the result cap is reached
					if (cnt_q == COUNT_BITS'(MAX_RESULTS)) begin
						state_q <= ST_NEXT;
					end else begin
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (k_q == TAP_IDX_BITS'(PHASE_TAPS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + TAP_IDX_BITS'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						pend_valid_q <= 1'b1;
						cnt_q <= cnt_q + COUNT_BITS'(1);
						if (given_q != '1) begin
							given_q <= given_q + LENGTH_BITS'(1);
						end
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (!p_q && (!flush_q || below_target)) begin
						p_q     <= 1'b1;
						state_q <= ST_START;
					end else if (flush_q) begin
						state_q <= ST_FLUSH;
					end else begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (last_q) begin
						flush_q <= 1'b1;
						pad_q   <= '0;
						state_q <= ST_FLUSH;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FLUSH: begin
					if (pad_q < FILL_BITS'(ZERO_TAIL) && below_target) begin
						for (int i = 0; i < PHASE_TAPS - 1; i++) begin
							dl_q[i] <= dl_q[i+1];
						end
						dl_q[PHASE_TAPS-1] <= '0;
						pad_q  <= pad_q + FILL_BITS'(1);
						ph_q   <= ph_next;
						fill_q <= fill_next;
						p_q    <= 1'b0;
						if (ph_q == 2'd0 && fill_full) begin
							state_q <= ST_START;
						end
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						pend_valid_q <= 1'b0;
						cnt_q        <= '0;
						if (last_q) begin
							for (int i = 0; i < PHASE_TAPS; i++) begin
								dl_q[i] <= '0;
							end
							seen_q  <= '0;
							given_q <= '0;
							ph_q    <= '0;
							fill_q  <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= dl_q[k_q] * coef_val;
		if (state_q == ST_START) begin
			acc_q <= '0;
		end else if (prod_v_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
		if (emit_go) begin
			pend_sample_q <= rounded;
		end
		if (push) begin
			out_data_q.out_sample  <= pend_sample_q;
			out_data_q.run_last    <= fin_go;
			out_data_q.stream_last <= fin_go && last_q;
		end
	end

`ifndef SYNTHESIS
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= COUNT_BITS'(MAX_RESULTS))
		else $error("result count above cap");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_valid_q && cnt_q == '0)
		else $error("pending word left over between items");

	a_stream_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.stream_last |-> out_data_q.run_last)
		else $error("stream_last without run_last");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q != 2'd3 && pad_q <= FILL_BITS'(ZERO_TAIL))
		else $error("phase or pad count out of range");

	a_drain_tap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> k_q == TAP_IDX_BITS'(PHASE_TAPS - 1) && prod_v_s1)
		else $error("tap walk ended early");
`endif

endmodule
